// ----- src/mcst_pkg.sv -----
// mcst_pkg: shared types and constants of the midi beat-clock tracker
// used by mcst_div and midi_clock_sync_tracker; no dependencies

package mcst_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RX    = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  localparam logic [1:0] MODE_MASTER = 2'd1;
  localparam logic [1:0] MODE_SLAVE  = 2'd2;

  localparam logic REG_SYNC_MODE    = 1'b0;
  localparam logic REG_MASTER_TEMPO = 1'b1;

  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;

  localparam logic [15:0] TEMPO_MIN   = 16'd15360;
  localparam logic [15:0] TEMPO_MAX   = 16'd46080;
  localparam logic [15:0] TEMPO_RESET = 16'd30720;

  // microseconds per minute times 256 (q8.8 tempo)
  localparam int unsigned DVD_W = 34;
  localparam logic [DVD_W-1:0] DIVIDEND = 34'd15360000000;

endpackage

// ----- src/mcst_div.sv -----
// mcst_div: restoring divider, one quotient bit per cycle, fixed dividend
// depends on mcst_pkg for the dividend and its width

module mcst_div
  import mcst_pkg::*;
#(
  parameter int unsigned DEN_W = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        den_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= DIVIDEND;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= DEN_W'(shifted - {1'b0, den_q});
        end else begin
          rem_q <= shifted[DEN_W-1:0];
        end
        quo_q <= {quo_q[DVD_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && den_q != '0 |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0 && cnt_q <= CNT_W'(DVD_W))
    else $error("divider step count out of range");

endmodule

// ----- src/midi_clock_sync_tracker.sv -----
// midi_clock_sync_tracker: midi beat clock master/slave with tempo tracking
// depends on mcst_pkg and mcst_div (shared iterative divider)
//
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+-----------------
//  in       | operation_i, rx_byte_i                        | in_valid/in_ready
//  out      | tx_valid_o, tx_byte_o, is_running_o,          | out_valid/out_ready
//           | tempo_out_o, phase_step_o                     |
//  cfg      | cfg_index_i, cfg_data_i                       | cfg_we_i, no wait
//
// ticks, stops, non-master starts and most received bytes finish in the cycle they are taken
// a master start request or a timed slave clock byte runs the shared divider:
// DVD_W quotient steps, then a done strobe, after which the result is registered;
// no other request is taken from the start of a division until its result is shown
// in_ready is low while the divider runs and while an unread result blocks the output
// after reset the block is stopped, mode off, master tempo 120 bpm

module midi_clock_sync_tracker
  import mcst_pkg::*;
#(
  parameter int unsigned CLOCKS_PER_BEAT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        is_running_o,
  output logic [15:0] tempo_out_o,
  output logic [4:0]  phase_step_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned DEN_W = 32 + $clog2(CLOCKS_PER_BEAT + 1);
  localparam int unsigned BI_W  = (CLOCKS_PER_BEAT > 1) ? $clog2(CLOCKS_PER_BEAT) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e            state_q;
  logic [1:0]        mode_q;
  logic [15:0]       mtempo_q;
  logic              running_q;
  logic [31:0]       elapsed_q;
  logic              seen_q;
  logic [BI_W-1:0]   beat_q;
  logic [15:0]       meas_q;
  logic [BI_W-1:0]   held_q;
  logic [15:0]       period_q;
  logic [15:0]       count_q;
  logic              div_master_q;

  logic              out_valid_q;
  logic              tx_valid_q;
  logic [7:0]        tx_byte_q;
  logic              is_running_q;
  logic [15:0]       tempo_q;
  logic [4:0]        phase_q;

  logic              in_acc;
  logic              running_d;
  logic [31:0]       elapsed_d;
  logic              seen_d;
  logic [BI_W-1:0]   beat_d;
  logic [BI_W-1:0]   held_d;
  logic [15:0]       count_d;
  logic [15:0]       count_dec;
  logic              tx_valid_d;
  logic [7:0]        tx_byte_d;
  logic              need_div;
  logic              div_master_d;
  logic [DEN_W-1:0]  den;
  logic [BI_W+4:0]   held_ext_d;
  logic [BI_W+4:0]   held_ext_q;

  logic              div_done;
  logic [DVD_W-1:0]  quot;
  logic [15:0]       quot_sat;
  logic [15:0]       quot_clamp;
  logic [15:0]       cfg_tempo;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    running_d    = running_q;
    elapsed_d    = elapsed_q;
    seen_d       = seen_q;
    beat_d       = beat_q;
    held_d       = held_q;
    count_d      = count_q;
    count_dec    = (count_q != 16'd0) ? count_q - 16'd1 : 16'd0;
    tx_valid_d   = 1'b0;
    tx_byte_d    = 8'h00;
    need_div     = 1'b0;
    div_master_d = 1'b0;
    den          = DEN_W'(mtempo_q) * DEN_W'(CLOCKS_PER_BEAT);
    unique case (op_e'(operation_i))
      OP_TICK: begin
        if (elapsed_q != 32'hFFFF_FFFF) begin
          elapsed_d = elapsed_q + 32'd1;
        end
        if (mode_q == MODE_MASTER && running_q) begin
          if (count_dec == 16'd0) begin
            tx_valid_d = 1'b1;
            tx_byte_d  = RT_CLOCK;
            count_d    = period_q;
          end else begin
            count_d = count_dec;
          end
        end
      end
      OP_RX: begin
        if (mode_q == MODE_SLAVE) begin
          unique case (rx_byte_i)
            RT_START: begin
              running_d = 1'b1;
              beat_d    = '0;
              elapsed_d = '0;
              seen_d    = 1'b1;
            end
            RT_STOP: begin
              running_d = 1'b0;
            end
            RT_CONTINUE: begin
              running_d = 1'b1;
              elapsed_d = '0;
              seen_d    = 1'b1;
            end
            RT_CLOCK: begin
              if (running_q && seen_q) begin
                if (elapsed_q != 32'd0) begin
                  need_div = 1'b1;
                  den      = DEN_W'(elapsed_q) * DEN_W'(CLOCKS_PER_BEAT);
                end
                held_d = beat_q;
              end
              elapsed_d = '0;
              seen_d    = 1'b1;
              beat_d    = (beat_q == BI_W'(CLOCKS_PER_BEAT - 1)) ? '0 : beat_q + BI_W'(1);
            end
            default: begin
            end
          endcase
        end
      end
      OP_START: begin
        if (mode_q == MODE_MASTER) begin
          need_div     = 1'b1;
          div_master_d = 1'b1;
          running_d    = 1'b1;
        end
      end
      OP_STOP: begin
        if (mode_q == MODE_MASTER) begin
          tx_valid_d = 1'b1;
          tx_byte_d  = RT_STOP;
          running_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign held_ext_d = {5'b0, held_d};
  assign held_ext_q = {5'b0, held_q};

  assign quot_sat = (quot > DVD_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
  always_comb begin
    if (quot < DVD_W'(TEMPO_MIN)) begin
      quot_clamp = TEMPO_MIN;
    end else if (quot > DVD_W'(TEMPO_MAX)) begin
      quot_clamp = TEMPO_MAX;
    end else begin
      quot_clamp = quot[15:0];
    end
  end

  always_comb begin
    if (cfg_data_i < TEMPO_MIN) begin
      cfg_tempo = TEMPO_MIN;
    end else if (cfg_data_i > TEMPO_MAX) begin
      cfg_tempo = TEMPO_MAX;
    end else begin
      cfg_tempo = cfg_data_i;
    end
  end

  mcst_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && need_div),
    .divisor_i(den),
    .done_o   (div_done),
    .quot_o   (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= 2'd0;
      mtempo_q     <= TEMPO_RESET;
      running_q    <= 1'b0;
      elapsed_q    <= '0;
      seen_q       <= 1'b0;
      beat_q       <= '0;
      meas_q       <= '0;
      held_q       <= '0;
      period_q     <= '0;
      count_q      <= '0;
      div_master_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tx_valid_q   <= 1'b0;
      tx_byte_q    <= '0;
      is_running_q <= 1'b0;
      tempo_q      <= '0;
      phase_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SYNC_MODE) begin
          mode_q <= cfg_data_i[1:0];
        end else begin
          mtempo_q <= cfg_tempo;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            running_q    <= running_d;
            elapsed_q    <= elapsed_d;
            seen_q       <= seen_d;
            beat_q       <= beat_d;
            held_q       <= held_d;
            count_q      <= count_d;
            div_master_q <= div_master_d;
            if (need_div) begin
              state_q     <= ST_DIV;
              out_valid_q <= 1'b0;
            end else begin
              out_valid_q  <= 1'b1;
              tx_valid_q   <= tx_valid_d;
              tx_byte_q    <= tx_byte_d;
              is_running_q <= running_d;
              tempo_q      <= (mode_q == MODE_SLAVE) ? meas_q : mtempo_q;
              phase_q      <= held_ext_d[4:0];
            end
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q      <= ST_IDLE;
            out_valid_q  <= 1'b1;
            is_running_q <= running_q;
            phase_q      <= held_ext_q[4:0];
            if (div_master_q) begin
              period_q   <= quot_sat;
              count_q    <= quot_sat;
              tx_valid_q <= 1'b1;
              tx_byte_q  <= RT_START;
              tempo_q    <= mtempo_q;
            end else begin
              meas_q     <= quot_clamp;
              tx_valid_q <= 1'b0;
              tx_byte_q  <= 8'h00;
              tempo_q    <= quot_clamp;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = tx_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign is_running_o = is_running_q;
  assign tempo_out_o  = tempo_q;
  assign phase_step_o = phase_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside a division");

  a_tx_byte_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !tx_valid_q |-> tx_byte_q == 8'h00)
    else $error("byte shown without a send");

  a_master_tempo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mtempo_q >= TEMPO_MIN && mtempo_q <= TEMPO_MAX)
    else $error("master tempo out of range");

  a_meas_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_q == 16'd0 || (meas_q >= TEMPO_MIN && meas_q <= TEMPO_MAX))
    else $error("measured tempo out of range");

  a_count_le_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= period_q)
    else $error("countdown above period");

endmodule

// ----- test/mcst_checker.sv -----
// mcst_checker: watches the request, result and register ports of the midi beat-clock tracker,
// predicts every result and compares it with what the block returns
// depends on mcst_pkg

module mcst_checker
  import mcst_pkg::*;
#(
  parameter int unsigned CLOCKS_PER_BEAT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        tx_valid_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        is_running_i,
  input  logic [15:0] tempo_out_i,
  input  logic [4:0]  phase_step_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        running;
    logic [15:0] tempo;
    logic [4:0]  phase;
  } midi_res_t;

  logic [1:0]  sync_mode;
  logic [15:0] master_tempo;
  logic        running;
  logic [31:0] elapsed_us;
  logic        stamp_seen;
  logic [4:0]  beat_idx;
  logic [15:0] slave_tempo;
  logic [4:0]  held_phase;
  logic [15:0] tick_period;
  logic [15:0] countdown;

  midi_res_t midi_expect_q[$];
  midi_res_t seen_res;
  midi_res_t want_res;

  function automatic logic [15:0] clamp_tempo(longint unsigned t);
    if (t < TEMPO_MIN) return TEMPO_MIN;
    if (t > TEMPO_MAX) return TEMPO_MAX;
    return 16'(t);
  endfunction

  // advances the tracker state by one request and returns the result it gives
  function midi_res_t next_midi_result(op_e op, logic [7:0] b);
    midi_res_t r;
    longint unsigned den;
    longint unsigned quo;
    r = '0;
    case (op)
      OP_TICK: begin
        if (elapsed_us != '1) elapsed_us++;
        if (sync_mode == MODE_MASTER && running) begin
          if (countdown != 0) countdown--;
          if (countdown == 0) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = RT_CLOCK;
            countdown  = tick_period;
          end
        end
      end
      OP_RX: begin
        if (sync_mode == MODE_SLAVE) begin
          case (b)
            RT_START: begin
              running    = 1'b1;
              beat_idx   = '0;
              elapsed_us = '0;
              stamp_seen = 1'b1;
            end
            RT_STOP: running = 1'b0;
            RT_CONTINUE: begin
              running    = 1'b1;
              elapsed_us = '0;
              stamp_seen = 1'b1;
            end
            RT_CLOCK: begin
              if (running && stamp_seen) begin
                if (elapsed_us != 0) begin
                  den = 64'(elapsed_us) * 64'(CLOCKS_PER_BEAT);
                  slave_tempo = clamp_tempo(DIVIDEND / den);
                end
                held_phase = beat_idx;
              end
              elapsed_us = '0;
              stamp_seen = 1'b1;
              beat_idx   = 5'((32'(beat_idx) + 1) % CLOCKS_PER_BEAT);
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        if (sync_mode == MODE_MASTER) begin
          den = 64'(master_tempo) * 64'(CLOCKS_PER_BEAT);
          quo = (den == 0) ? 64'hFFFF : DIVIDEND / den;
          tick_period = (quo > 64'hFFFF) ? 16'hFFFF : 16'(quo);
          countdown   = tick_period;
          running     = 1'b1;
          r.tx_valid  = 1'b1;
          r.tx_byte   = RT_START;
        end
      end
      OP_STOP: begin
        if (sync_mode == MODE_MASTER) begin
          running    = 1'b0;
          r.tx_valid = 1'b1;
          r.tx_byte  = RT_STOP;
        end
      end
      default: ;
    endcase
    r.running = running;
    r.tempo   = (sync_mode == MODE_SLAVE) ? slave_tempo : master_tempo;
    r.phase   = held_phase;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sync_mode    = '0;
      master_tempo = TEMPO_RESET;
      running      = 1'b0;
      elapsed_us   = '0;
      stamp_seen   = 1'b0;
      beat_idx     = '0;
      slave_tempo  = '0;
      held_phase   = '0;
      tick_period  = '0;
      countdown    = '0;
      fail_count_o = 0;
      midi_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SYNC_MODE) sync_mode = cfg_data_i[1:0];
        else master_tempo = clamp_tempo(64'(cfg_data_i));
      end
      if (in_valid_i && in_ready_i) begin
        midi_expect_q.push_back(next_midi_result(op_e'(operation_i), rx_byte_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen_res = {tx_valid_i, tx_byte_i, is_running_i, tempo_out_i, phase_step_i};
        if (midi_expect_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result with no request outstanding: tx %0b/%02h run %0b",
                     $time, seen_res.tx_valid, seen_res.tx_byte, seen_res.running);
          end
          fail_count_o++;
        end else begin
          want_res = midi_expect_q.pop_front();
          if (seen_res.tx_valid !== want_res.tx_valid || seen_res.tx_byte !== want_res.tx_byte
              || seen_res.running !== want_res.running || seen_res.tempo !== want_res.tempo
              || seen_res.phase !== want_res.phase) begin
            if (fail_count_o < 10) begin
              $display("%0t: got tx %0b/%02h run %0b tempo %0d phase %0d", $time,
                       seen_res.tx_valid, seen_res.tx_byte, seen_res.running,
                       seen_res.tempo, seen_res.phase);
              $display("%0t: exp tx %0b/%02h run %0b tempo %0d phase %0d", $time,
                       want_res.tx_valid, want_res.tx_byte, want_res.running,
                       want_res.tempo, want_res.phase);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o = midi_expect_q.size();
  end

endmodule

// ----- test/tb.sv -----
// tb: drives directed and random requests and register writes into the midi beat-clock
// tracker under changing idle patterns; mcst_checker judges every result
// depends on mcst_pkg, mcst_checker and midi_clock_sync_tracker

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mcst_pkg::*;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] PHASE_MODE [8] = '{MODE_SLAVE, MODE_MASTER, MODE_SLAVE, MODE_OFF,
                                            MODE_MASTER, MODE_SLAVE, MODE_SPARE, MODE_SLAVE};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        is_running;
  logic [15:0] tempo_out;
  logic [4:0]  phase_step;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_stall = 0;
  int req_count = 0;
  int quiet_cycles = 0;

  midi_clock_sync_tracker i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .is_running_o (is_running),
    .tempo_out_o  (tempo_out),
    .phase_step_o (phase_step),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  mcst_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .operation_i  (operation),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .tx_valid_i   (tx_valid),
    .tx_byte_i    (tx_byte),
    .is_running_i (is_running),
    .tempo_out_i  (tempo_out),
    .phase_step_i (phase_step),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_req(input op_e op, input logic [7:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rx_byte   <= b;
    do @(posedge clk); while (!in_ready);
    req_count++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_req(OP_TICK, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stop_at;
    logic [1:0] mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode off after reset, then the spare mode value
    send_req(OP_TICK, 8'h00);
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_START, 8'hFF);
    send_req(OP_STOP, 8'h00);
    write_reg(REG_SYNC_MODE, 16'hFFFF);
    send_req(OP_START, 8'h00);
    send_req(OP_STOP, 8'hFF);

    // slave: clock before any timing byte, ignored bytes, zero elapsed, stopped clock
    write_reg(REG_SYNC_MODE, {14'd0, MODE_SLAVE});
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_RX, 8'h00);
    send_req(OP_RX, 8'hFF);
    send_req(OP_RX, RT_CONTINUE);
    send_req(OP_TICK, 8'hFF);
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_RX, RT_STOP);
    send_req(OP_TICK, 8'h00);
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_START, 8'h00);
    send_req(OP_STOP, 8'h00);
    send_req(OP_RX, RT_START);
    send_req(OP_RX, RT_CLOCK);

    // master mode entered while the slave runs: clock bytes with no period loaded
    write_reg(REG_SYNC_MODE, {14'd0, MODE_MASTER});
    tick_run(4);

    // master at the slowest tempo: stop of the run left from slave mode, repeated start
    write_reg(REG_MASTER_TEMPO, 16'h0000);
    send_req(OP_STOP, 8'h00);
    send_req(OP_START, 8'hFF);
    send_req(OP_START, 8'h00);
    send_req(OP_RX, RT_CLOCK);
    send_req(OP_STOP, 8'hFF);

    // slave timing with short gaps
    write_reg(REG_SYNC_MODE, {14'd0, MODE_SLAVE});
    send_req(OP_RX, RT_START);
    for (int i = 0; i < 3; i++) begin
      tick_run($urandom_range(1, 12));
      send_req(OP_RX, RT_CLOCK);
    end

    // master at the fastest tempo, tempo and mode changed while running
    write_reg(REG_MASTER_TEMPO, 16'hFFFF);
    write_reg(REG_SYNC_MODE, {14'd0, MODE_MASTER});
    send_req(OP_START, 8'h00);
    tick_run(8);
    write_reg(REG_MASTER_TEMPO, TEMPO_MIN);
    tick_run(8);
    write_reg(REG_SYNC_MODE, {14'd0, MODE_SLAVE});
    tick_run(4);
    write_reg(REG_SYNC_MODE, {14'd0, MODE_MASTER});
    tick_run(8);
    send_req(OP_STOP, 8'h00);

    write_reg(REG_MASTER_TEMPO, 16'($urandom_range(TEMPO_MIN, TEMPO_MAX)));
    send_req(OP_START, 8'h00);
    tick_run(5);
    send_req(OP_STOP, 8'h00);

    for (int k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      mode = PHASE_MODE[k];
      case ($urandom_range(3))
        0: write_reg(REG_MASTER_TEMPO, 16'h0000);
        1: write_reg(REG_MASTER_TEMPO, 16'hFFFF);
        default: write_reg(REG_MASTER_TEMPO, 16'($urandom));
      endcase
      write_reg(REG_SYNC_MODE, {14'($urandom), mode});
      stop_at = req_count + 160;
      while (req_count < stop_at) begin
        if ($urandom_range(99) < 15 || (mode != MODE_SLAVE && mode != MODE_MASTER)) begin
          send_req(op_e'($urandom_range(3)),
                   ($urandom_range(3) == 0) ? 8'($urandom_range(RT_CLOCK, RT_STOP))
                                            : 8'($urandom));
        end else if (mode == MODE_SLAVE) begin
          send_req(OP_RX, $urandom_range(1) ? RT_START : RT_CONTINUE);
          repeat ($urandom_range(1, 10)) begin
            tick_run($urandom_range(0, 12));
            send_req(OP_RX, RT_CLOCK);
          end
          if ($urandom_range(1)) send_req(OP_RX, RT_STOP);
        end else begin
          send_req(OP_START, 8'($urandom));
          tick_run($urandom_range(0, 10));
          if ($urandom_range(3) == 0) send_req(OP_START, 8'($urandom));
          send_req(OP_STOP, 8'($urandom));
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
